FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define LKVC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lkvc assertion failed");

// Consequent checked in the cycle after the antecedent
`define LKVC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lkvc assertion failed");

`endif

FILE: sv/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Sizes, codes and word types of the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  // Number of cells in the recency chain
  localparam int Entries = 16;

  localparam int KeyW  = 32;
  localparam int ValW  = 32;
  localparam int CapW  = 5;
  localparam int OccW  = $clog2(Entries + 1);
  localparam int CmpW  = (OccW > CapW) ? OccW : CapW;

  localparam logic [CapW-1:0] CapReset = CapW'(16);

  typedef enum logic {
    ActGet = 1'b0,
    ActSet = 1'b1
  } action_e;

  // One stored entry as it moves down the chain
  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } entry_t;

  // Broadcast control to every cell
  typedef struct packed {
    logic active;   // an update takes place this cycle
    logic hit;      // the key sits in some cell
    logic evict;    // the store is at capacity (acted on only on a miss)
  } cell_ctrl_t;

endpackage

FILE: sv/lkvc_cell.sv
// ----------------------------------------------------------------------------
// lkvc_cell
// One place of the recency chain: holds an entry, compares it with the
// lookup key and takes the entry of its more recent neighbour on a shift.
// ----------------------------------------------------------------------------
module lkvc_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lkvc_pkg::cell_ctrl_t                ctrl_i,
  input  logic [lkvc_pkg::KeyW-1:0]           lookup_key_i,
  input  lkvc_pkg::entry_t                    prev_i,
  input  logic                                tail_seen_i,
  input  logic [lkvc_pkg::ValW-1:0]           tail_value_i,
  output lkvc_pkg::entry_t                    entry_o,
  output logic                                seen_o,
  output logic [lkvc_pkg::ValW-1:0]           value_o
);

  logic                        valid_q;
  logic [lkvc_pkg::KeyW-1:0]   key_q;
  logic [lkvc_pkg::ValW-1:0]   value_q;
  logic                        match;
  logic                        shift_en;

  // Compare against the lookup key
  assign match = valid_q && (key_q == lookup_key_i);

  // Pass hit presence and hit value towards the head
  assign seen_o  = tail_seen_i | match;
  assign value_o = tail_value_i | (match ? value_q : '0);

  // Shift when this place lies at or above the vacated slot
  always_comb begin
    if (ctrl_i.hit) begin
      shift_en = ctrl_i.active && (tail_seen_i || match);
    end else if (ctrl_i.evict) begin
      shift_en = ctrl_i.active && valid_q;
    end else begin
      shift_en = ctrl_i.active && prev_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_en) begin
      valid_q <= prev_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      key_q   <= prev_i.key;
      value_q <= prev_i.value;
    end
  end

  assign entry_o = '{valid: valid_q, key: key_q, value: value_q};

endmodule

FILE: sv/lru_key_value_cache_core.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// The store is a chain of cells ordered by recency, the head most recent.
// For each item, every cell compares its key at once and the
// chain shifts one place towards the tail up to the slot being freed, while
// the head takes the touched or new entry. One item is accepted per cycle;
// a get's result appears in the output register the cycle after acceptance.
// Input is stalled only while a result waits and the output is stalled.
// Capacity writes are taken at once and never clear the store.
module lru_key_value_cache_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // request words
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  action_i,
  input  logic signed [lkvc_pkg::KeyW-1:0]      key_i,
  input  logic signed [lkvc_pkg::ValW-1:0]      value_i,
  // result words
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  hit_o,
  output logic signed [lkvc_pkg::ValW-1:0]      read_value_o,
  // capacity register
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [lkvc_pkg::CapW-1:0]             cfg_data_i
);

  localparam int N = lkvc_pkg::Entries;

  logic [lkvc_pkg::CapW-1:0]   cap_q;
  logic [lkvc_pkg::OccW-1:0]   occ_q;
  logic [lkvc_pkg::CmpW-1:0]   eff_cap;
  logic                        accept;
  logic                        is_set;
  logic                        hit_any;
  logic                        evict;
  logic [lkvc_pkg::ValW-1:0]   hit_value;
  lkvc_pkg::cell_ctrl_t        ctrl;
  lkvc_pkg::entry_t            front;
  lkvc_pkg::entry_t            entry_w [N];
  logic                        seen_w  [N+1];
  logic [lkvc_pkg::ValW-1:0]   hv_w    [N+1];

  logic                        out_valid_q;
  logic                        hit_q;
  logic [lkvc_pkg::ValW-1:0]   rdval_q;

  // Handshakes
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign is_set      = (action_i == lkvc_pkg::ActSet);

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkvc_pkg::CapReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  // Clamp capacity to one through the chain length
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = lkvc_pkg::CmpW'(1);
    end else if (lkvc_pkg::CmpW'(cap_q) > lkvc_pkg::CmpW'(N)) begin
      eff_cap = lkvc_pkg::CmpW'(N);
    end else begin
      eff_cap = lkvc_pkg::CmpW'(cap_q);
    end
  end

  assign hit_any   = seen_w[0];
  assign hit_value = hv_w[0];
  assign evict     = (lkvc_pkg::CmpW'(occ_q) >= eff_cap);

  assign ctrl = '{active: accept && (is_set || hit_any), hit: hit_any, evict: evict};

  // Word entering the head: new value on set, stored value on get hit
  assign front = '{valid: 1'b1, key: key_i, value: (is_set ? value_i : hit_value)};

  assign seen_w[N] = 1'b0;
  assign hv_w[N]   = '0;

  // Recency chain
  for (genvar i = 0; i < N; i++) begin : g_cell
    lkvc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .lookup_key_i (key_i),
      .prev_i       ((i == 0) ? front : entry_w[(i == 0) ? 0 : i-1]),
      .tail_seen_i  (seen_w[i+1]),
      .tail_value_i (hv_w[i+1]),
      .entry_o      (entry_w[i]),
      .seen_o       (seen_w[i]),
      .value_o      (hv_w[i])
    );
  end

  // Count entries; eviction keeps the count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (accept && is_set && !hit_any && !evict) begin
      occ_q <= occ_q + lkvc_pkg::OccW'(1);
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && !is_set) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !is_set) begin
      hit_q   <= hit_any;
      rdval_q <= hit_any ? hit_value : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign read_value_o = $signed(rdval_q);

endmodule

FILE: sv/lkvc_checker.sv
// ----------------------------------------------------------------------------
// lkvc_checker
// Port-level checks of the LRU key-value cache, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lkvc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              action_i,
  input logic [lkvc_pkg::KeyW-1:0]         key_i,
  input logic [lkvc_pkg::ValW-1:0]         value_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic                              hit_o,
  input logic [lkvc_pkg::ValW-1:0]         read_value_o
);

  logic in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  // Hold a stalled result word
  `LKVC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // A miss reports zero
  `LKVC_ASSERT_SAME(a_miss_zero, out_valid_o && !hit_o, read_value_o == '0)

  // Every accepted get yields a word next cycle
  `LKVC_ASSERT_NEXT(a_get_result, in_acc && (action_i == lkvc_pkg::ActGet), out_valid_o)

  // A set on an idle output yields no word
  `LKVC_ASSERT_NEXT(a_set_silent,
    in_acc && (action_i == lkvc_pkg::ActSet) && !out_valid_o, !out_valid_o)

  // A get straight after a set of the same key hits with the new value
  `LKVC_ASSERT_NEXT(a_set_then_get,
    (in_acc && (action_i == lkvc_pkg::ActSet)) ##1
      (in_acc && (action_i == lkvc_pkg::ActGet) && (key_i == $past(key_i))),
    hit_o && (read_value_o == $past(value_i, 2)))

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .action_i     (action_i),
  .key_i        (key_i),
  .value_i      (value_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .hit_o        (hit_o),
  .read_value_o (read_value_o)
);

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LRU key-value cache core. A typed table of
// requests comes first: empty-store reads, extreme keys and values, updates,
// and capacity writes of zero, of the top code and low values. Random phases
// follow, one per capacity setting, over small key pools so that the store
// fills and evicts. A behavioural copy of the cache predicts every untyped
// read word; the checker compares each returned word with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int ResetCycles   = 9;
  localparam int SettleCycles  = 4;
  localparam int HoldOffCycles = 150;
  localparam int WordsPerPhase = 150;
  localparam int PoolDepth     = 24;
  localparam int PressurePhase = 2;
  localparam int LimitNs       = 4_000_000;

  typedef enum logic {
    RowWord = 1'b0,
    RowCap  = 1'b1
  } row_kind_e;

  // One line of the directed table: a request word or a capacity write
  typedef struct packed {
    row_kind_e                       kind;
    lkvc_pkg::action_e               act;
    logic [lkvc_pkg::KeyW-1:0]       key;
    logic [lkvc_pkg::ValW-1:0]       value;
    logic [lkvc_pkg::CapW-1:0]       cap;
    logic                            typed;
    logic                            exp_hit;
    logic [lkvc_pkg::ValW-1:0]       exp_value;
  } plan_row_t;

  typedef struct packed {
    logic                            hit;
    logic [lkvc_pkg::ValW-1:0]       value;
  } read_word_t;

  localparam plan_row_t Plan [24 + 4] = '{
    // empty store, extreme keys and values
    '{RowWord, lkvc_pkg::ActGet, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1, 1'b0, 32'h0000_0000},
    '{RowWord, lkvc_pkg::ActGet, 32'h8000_0000, 32'hFFFF_FFFF, 5'd0, 1'b1, 1'b0, 32'h0000_0000},
    '{RowWord, lkvc_pkg::ActSet, 32'h7FFF_FFFF, 32'h8000_0000, 5'd0, 1'b0, 1'b0, 32'h0000_0000},
    '{RowWord, lkvc_pkg::ActGet, 32'h7FFF_FFFF, 32'h0000_0000, 5'd0, 1'b1, 1'b1, 32'h8000_0000},
    '{RowWord, lkvc_pkg::ActSet, 32'h8000_0000, 32'h7FFF_FFFF, 5'd0, 1'b0, 1'b0, 32'h0000_0000},
    '{RowWord, lkvc_pkg::ActGet, 32'h8000_0000, 32'h0000_0000, 5'd0, 1'b1, 1'b1, 32'h7FFF_FFFF},
    '{RowWord, lkvc_pkg::ActSet, 32'h0000_0000, 32'hFFFF_FFFF, 5'd0, 1'b0, 1'b0, 32'h0000_0000},
    '{RowWord, lkvc_pkg::ActGet, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1, 1'b1, 32'hFFFF_FFFF},
    // update of a present key; a get ignores its value field
    '{RowWord, lkvc_pkg::ActSet, 32'h7FFF_FFFF, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0000_0000},
    '{RowWord, lkvc_pkg::ActGet, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 5'd0, 1'b1, 1'b1, 32'h0000_0000},
    '{RowWord, lkvc_pkg::ActGet, 32'hFFFF_FFFF, 32'h0000_0000, 5'd0, 1'b1, 1'b0, 32'h0000_0000},
    // capacity zero acts as one, below the occupancy: one eviction per insert
    '{RowCap,  lkvc_pkg::ActGet, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0000_0000},
    '{RowWord, lkvc_pkg::ActSet, 32'h0000_0005, 32'h0000_0055, 5'd0, 1'b0, 1'b0, 32'h0000_0000},
    '{RowWord, lkvc_pkg::ActGet, 32'h8000_0000, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0000_0000},
    '{RowWord, lkvc_pkg::ActGet, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0000_0000},
    '{RowWord, lkvc_pkg::ActGet, 32'h0000_0005, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0000_0000},
    // top capacity code saturates
    '{RowCap,  lkvc_pkg::ActGet, 32'h0000_0000, 32'h0000_0000, 5'd31, 1'b0, 1'b0, 32'h0000_0000},
    '{RowWord, lkvc_pkg::ActSet, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 5'd0, 1'b0, 1'b0, 32'h0000_0000},
    '{RowWord, lkvc_pkg::ActGet, 32'hA5A5_A5A5, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0000_0000},
    // small capacity: evict the least recent on a fresh key
    '{RowCap,  lkvc_pkg::ActGet, 32'h0000_0000, 32'h0000_0000, 5'd2, 1'b0, 1'b0, 32'h0000_0000},
    '{RowWord, lkvc_pkg::ActSet, 32'h0000_0010, 32'h0000_0001, 5'd0, 1'b0, 1'b0, 32'h0000_0000},
    '{RowWord, lkvc_pkg::ActSet, 32'h0000_0011, 32'h0000_0002, 5'd0, 1'b0, 1'b0, 32'h0000_0000},
    '{RowWord, lkvc_pkg::ActGet, 32'h0000_0010, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0000_0000},
    '{RowWord, lkvc_pkg::ActSet, 32'h0000_0012, 32'h0000_0003, 5'd0, 1'b0, 1'b0, 32'h0000_0000},
    '{RowWord, lkvc_pkg::ActGet, 32'h0000_0011, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0000_0000},
    '{RowWord, lkvc_pkg::ActGet, 32'h0000_0012, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0000_0000},
    '{RowCap,  lkvc_pkg::ActGet, 32'h0000_0000, 32'h0000_0000, 5'd17, 1'b0, 1'b0, 32'h0000_0000},
    '{RowWord, lkvc_pkg::ActGet, 32'h0000_0010, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0000_0000}
  };

  localparam logic [lkvc_pkg::CapW-1:0] PhaseCaps [11] = '{
    5'd16, 5'd1, 5'd4, 5'd31, 5'd0, 5'd8, 5'd17, 5'd2, 5'd12, 5'd3, 5'd16
  };

  logic                             clk_i;
  logic                             rst_ni;
  logic                             in_valid_i;
  logic                             in_stall_o;
  logic                             action_i;
  logic signed [lkvc_pkg::KeyW-1:0] key_i;
  logic signed [lkvc_pkg::ValW-1:0] value_i;
  logic                             out_valid_o;
  logic                             out_stall_i;
  logic                             hit_o;
  logic signed [lkvc_pkg::ValW-1:0] read_value_o;
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic [lkvc_pkg::CapW-1:0]        cfg_data_i;

  // Behavioural copy of the store
  logic [lkvc_pkg::KeyW-1:0] cache_key  [lkvc_pkg::Entries];
  logic [lkvc_pkg::ValW-1:0] cache_val  [lkvc_pkg::Entries];
  bit                        cache_live [lkvc_pkg::Entries];
  int unsigned               cache_age  [lkvc_pkg::Entries];
  int unsigned               cache_fill;
  logic [lkvc_pkg::CapW-1:0] cache_cap;
  read_word_t                pending_reads [$];

  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_off_req;
  int requests_sent;
  int reads_checked;
  int read_hits;
  int cap_writes;
  int mismatches;

  lru_key_value_cache_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hit_o        (hit_o),
    .read_value_o (read_value_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Capacity in force: zero acts as one, anything above the store size saturates
  function automatic int unsigned usable_slots();
    int unsigned c;
    c = cache_cap;
    if (c == 0) c = 1;
    if (c > lkvc_pkg::Entries) c = lkvc_pkg::Entries;
    return c;
  endfunction

  function automatic int find_slot(input logic [lkvc_pkg::KeyW-1:0] k);
    for (int i = 0; i < lkvc_pkg::Entries; i++)
      if (cache_live[i] && cache_key[i] == k) return i;
    return -1;
  endfunction

  // Make a slot most recent; the ones ahead of it age by one
  function automatic void promote(input int s);
    int unsigned r;
    r = cache_age[s];
    for (int i = 0; i < lkvc_pkg::Entries; i++)
      if (cache_live[i] && cache_age[i] < r) cache_age[i]++;
    cache_age[s] = 0;
  endfunction

  // Advance the copy by one request; returns 1 where a read word results
  function automatic bit apply_request(input lkvc_pkg::action_e act,
                                       input logic [lkvc_pkg::KeyW-1:0] k,
                                       input logic [lkvc_pkg::ValW-1:0] v,
                                       output read_word_t rd);
    int s;
    int slot;
    s    = find_slot(k);
    slot = -1;
    rd   = '0;
    if (act == lkvc_pkg::ActGet) begin
      if (s >= 0) begin
        promote(s);
        rd.hit   = 1'b1;
        rd.value = cache_val[s];
      end
      return 1'b1;
    end
    if (s >= 0) begin
      cache_val[s] = v;
      promote(s);
    end else if (cache_fill >= usable_slots()) begin
      // reuse the least recent slot
      for (int i = 0; i < lkvc_pkg::Entries; i++)
        if (cache_live[i] && (slot < 0 || cache_age[i] > cache_age[slot])) slot = i;
      cache_key[slot] = k;
      cache_val[slot] = v;
      promote(slot);
    end else begin
      for (int i = 0; i < lkvc_pkg::Entries; i++)
        if (!cache_live[i] && slot < 0) slot = i;
      for (int i = 0; i < lkvc_pkg::Entries; i++)
        if (cache_live[i]) cache_age[i]++;
      cache_key[slot]  = k;
      cache_val[slot]  = v;
      cache_live[slot] = 1'b1;
      cache_age[slot]  = 0;
      cache_fill++;
    end
    return 1'b0;
  endfunction

  // Offer one request word, with an optional idle burst ahead of it
  task automatic send_request(input lkvc_pkg::action_e act,
                              input logic [lkvc_pkg::KeyW-1:0] k,
                              input logic [lkvc_pkg::ValW-1:0] v, input bit typed,
                              input read_word_t typed_rd);
    int gap;
    read_word_t rd;
    if (tx_idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    action_i   <= act;
    key_i      <= k;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    if (apply_request(act, k, v, rd)) pending_reads.push_back(typed ? typed_rd : rd);
    requests_sent++;
  endtask

  // Drop valid, wait for every read word, then let the pipeline settle
  task automatic drain_pipeline();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [lkvc_pkg::CapW-1:0] cap);
    drain_pipeline();
    cfg_data_i  <= cap;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cache_cap = cap;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cap_writes++;
  endtask

  // Result back-pressure: random bursts, plus one long hold-off on request
  initial begin : result_stall
    int stall_left;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HoldOffCycles - 1;
        out_stall_i <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 11) == 0) begin
        stall_left   = $urandom_range(0, 18);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare each accepted read word with the oldest prediction
  always @(posedge clk_i) begin : read_checker
    read_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reads.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected read word, expected none, got hit=%0b value=%h",
                 $time, hit_o, read_value_o);
      end else begin
        want = pending_reads.pop_front();
        reads_checked++;
        if (hit_o) read_hits++;
        if (hit_o !== want.hit) begin
          mismatches++;
          $display("%0t: hit mismatch, expected %0b, got %0b", $time, want.hit, hit_o);
        end
        if (read_value_o !== want.value) begin
          mismatches++;
          $display("%0t: read_value mismatch, expected %h, got %h",
                   $time, want.value, read_value_o);
        end
      end
    end
  end

  initial begin : request_driver
    plan_row_t                 row;
    read_word_t                typed_rd;
    logic [lkvc_pkg::KeyW-1:0] key_pool [PoolDepth];
    logic [lkvc_pkg::KeyW-1:0] k;
    lkvc_pkg::action_e         act;
    int                        span;
    bit                        last_phase;

    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    action_i     = 1'b0;
    key_i        = '0;
    value_i      = '0;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = '0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    hold_off_req = 1'b0;
    foreach (cache_live[i]) begin
      cache_live[i] = 1'b0;
      cache_age[i]  = 0;
    end
    cache_fill = 0;
    cache_cap  = lkvc_pkg::CapReset;

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table
    foreach (Plan[i]) begin
      row = Plan[i];
      if (row.kind == RowCap) begin
        write_capacity(row.cap);
      end else begin
        typed_rd.hit   = row.exp_hit;
        typed_rd.value = row.exp_value;
        send_request(row.act, row.key, row.value, row.typed, typed_rd);
      end
    end

    // Random phases, one per capacity; keys mostly from a pool a little
    // larger than the capacity, so hits, misses and evictions all occur
    foreach (PhaseCaps[p]) begin
      write_capacity(PhaseCaps[p]);
      last_phase = (p == $size(PhaseCaps) - 1);
      tx_idle_on = !last_phase && ($urandom_range(0, 3) != 0);
      rx_idle_on = !last_phase && ($urandom_range(0, 3) != 0);
      if (p == PressurePhase) begin
        tx_idle_on   = 1'b0;
        hold_off_req = 1'b1;
      end
      foreach (key_pool[j]) key_pool[j] = $urandom;
      span = usable_slots() + 4;
      if (span > PoolDepth) span = PoolDepth;
      repeat (WordsPerPhase) begin
        act = ($urandom_range(0, 1) == 0) ? lkvc_pkg::ActGet : lkvc_pkg::ActSet;
        if ($urandom_range(0, 9) == 0) k = $urandom;
        else k = key_pool[$urandom_range(0, span - 1)];
        send_request(act, k, $urandom, 1'b0, '0);
      end
    end

    drain_pipeline();
    $display("Sent %0d requests over %0d capacity writes, capacities 0 to 31.",
             requests_sent, cap_writes);
    $display("Checked %0d read words (%0d hits), with one %0d-cycle result hold-off.",
             reads_checked, read_hits, HoldOffCycles);
    if (mismatches == 0 && pending_reads.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hard stop for a hung handshake
  initial begin : run_limit
    #(LimitNs);
    $display("Timeout with %0d read words outstanding", pending_reads.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/lkvc_pkg.sv
sv/lkvc_cell.sv
sv/lru_key_value_cache_core.sv
sv/lkvc_checker.sv
tb/sv/testbench.sv
